// File: hw/rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg - shared types and constants of the PCM sample encoder
// Item classification, the queued item format and the scale factors.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  // Outcome class decided by the front part
  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,  // zero, denormal, NaN or too small to reach one code step
    KIND_SAT   = 2'd1,  // infinity or magnitude far beyond full scale
    KIND_INT16 = 2'd2,  // integer sample, held in the low bits of mant
    KIND_FLOAT = 2'd3   // normal float needing the multiply
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic        wide;   // 24-bit output
    logic        be;     // most significant byte first
    logic [5:0]  shift;  // right shift of the rounded product, 1 to 47
    logic [23:0] mant;   // significand with hidden bit, or the int16 sample
  } pse_item_t;

  localparam logic [22:0] SCALE24 = 23'd8388607;
  localparam logic [22:0] SCALE16 = 23'd32767;

  // Float exponent bounds: at or above EXP_BIAS_SHIFT the product always
  // saturates, at or below EXP_ZERO it always truncates to zero
  localparam logic [7:0] EXP_BIAS_SHIFT = 8'd150;
  localparam logic [7:0] EXP_ZERO       = 8'd102;
  localparam logic [7:0] EXP_SPECIAL    = 8'd255;

  localparam logic [1:0] COUNT24 = 2'd3;
  localparam logic [1:0] COUNT16 = 2'd2;

  localparam logic [0:0] REG_DEPTH_IS_24 = 1'd0;
  localparam logic [0:0] REG_BIG_ENDIAN  = 1'd1;

endpackage

`default_nettype wire

// File: hw/rtl/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front - input register and sample classifier
// Accepts samples, decodes the float fields and registers a queued item.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              req_type,
  input  wire logic [31:0]       sample_word,
  input  wire logic              depth_is_24,
  input  wire logic              big_endian,
  output      logic              item_valid,
  input  wire logic              item_ready,
  output      pse_pkg::pse_item_t item
);

  pse_pkg::pse_item_t item_next;
  logic [7:0]         expo;
  logic [7:0]         shift_full;

  assign in_ready   = !item_valid || item_ready;
  assign expo       = sample_word[30:23];
  assign shift_full = pse_pkg::EXP_BIAS_SHIFT - expo;

  always_comb begin
    item_next       = '0;
    item_next.neg   = sample_word[31];
    item_next.wide  = depth_is_24;
    item_next.be    = big_endian;
    item_next.shift = shift_full[5:0];
    item_next.mant  = {1'b1, sample_word[22:0]};
    if (req_type) begin
      item_next.kind = pse_pkg::KIND_INT16;
      item_next.mant = {8'h00, sample_word[15:0]};
    end else if (expo == 8'd0) begin
      item_next.kind = pse_pkg::KIND_ZERO;
    end else if (expo == pse_pkg::EXP_SPECIAL) begin
      // NaN drops to zero, infinity saturates
      item_next.kind = (sample_word[22:0] != 23'd0) ? pse_pkg::KIND_ZERO
                                                    : pse_pkg::KIND_SAT;
    end else if (expo >= pse_pkg::EXP_BIAS_SHIFT) begin
      item_next.kind = pse_pkg::KIND_SAT;
    end else if (expo <= pse_pkg::EXP_ZERO) begin
      item_next.kind = pse_pkg::KIND_ZERO;
    end else begin
      item_next.kind = pse_pkg::KIND_FLOAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pse_queue.sv
// ----------------------------------------------------------------------------
// pse_queue - two-entry item queue
// Decouples the classifier from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_valid,
  output      logic               wr_ready,
  input  wire pse_pkg::pse_item_t wr_item,
  output      logic               rd_valid,
  input  wire logic               rd_ready,
  output      pse_pkg::pse_item_t rd_item
);

  pse_pkg::pse_item_t slots [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back - scaling, rounding, saturation and byte ordering
// Three register stages: product, float32 rounding, final code and bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output      logic               item_ready,
  input  wire pse_pkg::pse_item_t item,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [23:0]        pcm_bytes,
  output      logic [1:0]         byte_count
);

  // stage registers
  logic               v1, v2;
  pse_pkg::pse_item_t it1, it2;
  logic [46:0]        prod;
  logic [47:0]        rnd;
  logic               rdy1, rdy2, rdy3;

  // stage 1
  logic [22:0] scale;
  logic [46:0] prod_next;

  // stage 2
  logic        top;
  logic [5:0]  drop;
  logic [47:0] p48, keep, mask, rem, half, rnd_next;
  logic        up;

  // stage 3
  logic [47:0] mag;
  logic        sat;
  logic [23:0] sval;
  logic [23:0] code;
  logic [23:0] bytes_next;

  assign rdy3       = !out_valid || out_ready;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign item_ready = rdy1;

  assign scale     = item.wide ? pse_pkg::SCALE24 : pse_pkg::SCALE16;
  assign prod_next = item.mant * scale;

  // Round the exact product to 24 significant bits, nearest even
  always_comb begin
    top  = it1.wide ? prod[46] : prod[38];
    drop = it1.wide ? (top ? 6'd23 : 6'd22) : (top ? 6'd15 : 6'd14);
    p48  = {1'b0, prod};
    keep = p48 >> drop;
    mask = (48'd1 << drop) - 48'd1;
    rem  = p48 & mask;
    half = 48'd1 << (drop - 6'd1);
    up   = (rem > half) || ((rem == half) && keep[0]);
    rnd_next = (keep + {47'd0, up}) << drop;
  end

  always_comb begin
    mag  = rnd >> it2.shift;
    sat  = it2.wide ? (mag[47:23] != 25'd0) : (mag[47:15] != 33'd0);
    sval = it2.neg ? (24'd0 - mag[23:0]) : mag[23:0];
    unique case (it2.kind)
      pse_pkg::KIND_ZERO:  code = 24'd0;
      pse_pkg::KIND_SAT:   code = it2.neg ? 24'h800000 : 24'h7FFFFF;
      pse_pkg::KIND_INT16: code = it2.wide ? {it2.mant[15:0], 8'h00}
                                           : {8'h00, it2.mant[15:0]};
      pse_pkg::KIND_FLOAT: code = sat ? (it2.neg ? 24'h800000 : 24'h7FFFFF) : sval;
      default:             code = 24'd0;
    endcase
    if (!it2.wide) begin
      // narrow saturation codes are 0x8000 and 0x7FFF; other narrow codes keep the low 16 bits
      if ((it2.kind == pse_pkg::KIND_SAT) ||
          ((it2.kind == pse_pkg::KIND_FLOAT) && sat)) begin
        code = it2.neg ? 24'h008000 : 24'h007FFF;
      end else begin
        code = {8'h00, code[15:0]};
      end
    end
    if (it2.wide) begin
      bytes_next = it2.be ? {code[7:0], code[15:8], code[23:16]} : code;
    end else begin
      bytes_next = it2.be ? {8'h00, code[7:0], code[15:8]} : code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= item_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      it1  <= item;
      prod <= prod_next;
    end
    if (rdy2) begin
      it2 <= it1;
      rnd <= rnd_next;
    end
    if (rdy3) begin
      pcm_bytes  <= bytes_next;
      byte_count <= it2.wide ? pse_pkg::COUNT24 : pse_pkg::COUNT16;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pcm_sample_encoder_unit.sv
// ----------------------------------------------------------------------------
// pcm_sample_encoder_unit - float32 / int16 audio sample to PCM byte packer
// Encodes one sample per transaction into 16-bit or 24-bit PCM bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries req_type and sample_word: a
//   float32 pattern, or an int16 in bits 15:0. Output channel
//   (out_valid/out_ready) returns pcm_bytes, first byte in bits 7:0, and
//   byte_count (2 or 3). Every input transaction yields one output.
//   Configuration: cfg_we writes cfg_data bit 0 to register cfg_index
//   (0 depth_is_24, 1 big_endian). Write only while the unit is empty.
//   Throughput: one sample per clock while out_ready stays high. The
//   float path runs through the 24x23 multiplier stage followed by the
//   rounding stage.
//   Structure: classifier register, two-entry queue, then a three-stage
//   back end (multiply, round to float32, truncate/saturate/order bytes).
//   When the receiver stalls, the output holds and the back end, queue
//   and front fill in turn before in_ready drops.
//   Reset: clears all valid flags and the queue; depth_is_24 returns to 1,
//   big_endian to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_sample_encoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [0:0]  cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        req_type,
  input  wire logic [31:0] sample_word,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [23:0] pcm_bytes,
  output      logic [1:0]  byte_count
);

  logic               depth_is_24;
  logic               big_endian;

  logic               f_valid, f_ready;
  pse_pkg::pse_item_t f_item;
  logic               q_valid, q_ready;
  pse_pkg::pse_item_t q_item;

  // Configuration registers; only bit 0 of the data is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_is_24 <= 1'b1;
      big_endian  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pse_pkg::REG_DEPTH_IS_24: depth_is_24 <= cfg_data[0];
        pse_pkg::REG_BIG_ENDIAN:  big_endian  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify and register the incoming sample
  pse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .sample_word (sample_word),
    .depth_is_24 (depth_is_24),
    .big_endian  (big_endian),
    .item_valid  (f_valid),
    .item_ready  (f_ready),
    .item        (f_item)
  );

  // Hold classified items so front and back stall independently
  pse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // Scale, round, saturate and order the bytes
  pse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pcm_bytes  (pcm_bytes),
    .byte_count (byte_count)
  );

endmodule

`default_nettype wire

// File: hw/rtl/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker - port-level checks for the PCM sample encoder
// Watches reset behaviour, output holding and the shape of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] pcm_bytes,
  input wire logic [1:0]  byte_count
);

  // No result may appear straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pcm_bytes) && $stable(byte_count))
    else $error("stalled result changed");

  // Byte count is always 2 or 3
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count == 2'd2) || (byte_count == 2'd3))
    else $error("bad byte count");

  // A 16-bit result leaves the unused top byte clear
  a_unused_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_count == 2'd2) |-> pcm_bytes[23:16] == 8'h00)
    else $error("unused byte not zero");

  // Ready to accept right after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind pcm_sample_encoder_unit pse_checker u_pse_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pcm_bytes  (pcm_bytes),
  .byte_count (byte_count)
);

`default_nettype wire
